[src/fmma_pkg.sv]
// shared types, constants and binary32 rounding helper for the matrix multiply-accumulate block
// no dependencies; imported by every module of the block

package fmma_pkg;

  // default store dimension (rows and columns of each store)
  localparam int unsigned MAX_DIM_DEF = 16;

  localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

  // configuration register indexes
  localparam logic [1:0] REG_ROWS_M  = 2'd0;
  localparam logic [1:0] REG_INNER_K = 2'd1;
  localparam logic [1:0] REG_COLS_N  = 2'd2;

  localparam logic [4:0] DIM_RESET = 5'd16;

  typedef enum logic [2:0] {
    CMD_WR_A    = 3'd0,
    CMD_WR_B    = 3'd1,
    CMD_WR_C    = 3'd2,
    CMD_COMPUTE = 3'd3,
    CMD_RD_C    = 3'd4
  } fmma_cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_C,
    ST_C_LD,
    ST_C_ACC,
    ST_AB_RD,
    ST_MUL,
    ST_MRND,
    ST_ADD,
    ST_ARND,
    ST_WB
  } fmma_state_e;

  typedef struct packed {
    logic [2:0]  command;
    logic [3:0]  row;
    logic [3:0]  col;
    logic [31:0] value;
  } fmma_in_t;

  typedef struct packed {
    logic [3:0]  row_res;
    logic [3:0]  col_res;
    logic [31:0] value_res;
  } fmma_out_t;

  // controller to datapath commands
  typedef struct packed {
    logic wr_a;
    logic wr_b;
    logic wr_c;
    logic rd_host;
    logic out_load;
    logic c_rd;
    logic acc_load;
    logic ab_rd;
    logic mul_en;
    logic mrnd_en;
    logic add_en;
    logic arnd_en;
    logic wb;
    logic k_clr;
    logic k_inc;
    logic ij_clr;
    logic ij_inc;
  } fmma_ctl_t;

  // datapath to controller status
  typedef struct packed {
    logic k_last;
    logic j_last;
    logic i_last;
    logic empty;
  } fmma_stat_t;

  // normalize and round to binary32, nearest even, subnormals kept;
  // x has its reference leading bit at position 49, which stands for biased exponent e
  function automatic logic [31:0] norm_round(input logic sign, input logic signed [11:0] e,
                                             input logic [50:0] x);
    logic [5:0]         lz;
    logic [50:0]        n;
    logic [50:0]        mask;
    logic signed [12:0] ee;
    logic [5:0]         rsh;
    logic               sticky;
    logic               rnd;
    logic [24:0]        r;
    logic [7:0]         ef;
    logic [31:0]        res;
    lz     = '0;
    sticky = 1'b0;
    rsh    = '0;
    mask   = '0;
    for (int b = 0; b < 51; b++) begin
      if (x[b]) lz = 6'(50 - b);
    end
    n  = x << lz;
    ee = $signed({e[11], e}) + 13'sd1 - $signed({7'b0, lz});
    // subnormal range: shift right, collect sticky
    if (ee < 13'sd1) begin
      if (ee < -13'sd49) begin
        sticky = |n;
        n      = '0;
      end else begin
        rsh    = 6'(13'sd1 - ee);
        mask   = (51'(1) << rsh) - 51'(1);
        sticky = |(n & mask);
        n      = n >> rsh;
      end
      ee = 13'sd1;
    end
    rnd = n[26] & (sticky | (|n[25:0]) | n[27]);
    r   = {1'b0, n[50:27]} + 25'(rnd);
    if (r[24]) begin
      r  = r >> 1;
      ee = ee + 13'sd1;
    end
    ef = r[23] ? ee[7:0] : 8'h00;
    if (x == '0) begin
      res = {sign, 31'b0};
    end else if (ee > 13'sd254) begin
      res = {sign, 8'hFF, 23'b0};
    end else begin
      res = {sign, ef, r[22:0]};
    end
    return res;
  endfunction

endpackage

[src/float_matrix_multiply_accumulate.sv]
// A write or unknown command leaves the controller idle; a read passes through ST_RD_C, which
// waits for a free output register; the result is held there until taken. While idle, one
// write is taken per cycle; a read blocks the input until its result is loaded. Unless a
// dimension is zero, each multiply-add step of a compute runs operand read, multiply, product
// rounding, align-add and sum rounding through one shared unit.
// Reset clears the controller, output valid and registers (rows_m, inner_k, cols_n = 16);
// the A, B and C stores are not cleared and are undefined until written.

module float_matrix_multiply_accumulate import fmma_pkg::*; #(
  parameter int unsigned MaxDim = MAX_DIM_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  fmma_in_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output fmma_out_t  out_data_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [4:0] cfg_wdata_i
);

  logic [4:0] rows_m_q, inner_k_q, cols_n_q;
  fmma_ctl_t  ctl;
  fmma_stat_t stat;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_m_q  <= DIM_RESET;
      inner_k_q <= DIM_RESET;
      cols_n_q  <= DIM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ROWS_M:  rows_m_q  <= cfg_wdata_i;
        REG_INNER_K: inner_k_q <= cfg_wdata_i;
        REG_COLS_N:  cols_n_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  fmma_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (in_data_i.command),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .ctl_o       (ctl)
  );

  fmma_datapath #(
    .MaxDim (MaxDim)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .rows_m_i   (rows_m_q),
    .inner_k_i  (inner_k_q),
    .cols_n_i   (cols_n_q),
    .ctl_i      (ctl),
    .stat_o     (stat),
    .out_data_o (out_data_o)
  );

  // a pending result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.out_load |-> (!out_valid_o || out_ready_i))
    else $error("result register overwritten");

  // an accepted read blocks the input until its result is loaded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_data_i.command == CMD_RD_C) |=> !in_ready_o)
    else $error("input accepted during a read transaction");

  // compute write-back never collides with a host write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.wb |-> (!ctl.wr_c && !in_ready_o))
    else $error("write-back collides with host write");

endmodule

[src/fmma_ctrl.sv]
// controller state machine: handshake, command decode and compute sequencing
// depends on fmma_pkg

module fmma_ctrl import fmma_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] command_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  fmma_stat_t stat_i,
  output fmma_ctl_t  ctl_o
);

  fmma_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        accept;
  logic        out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i & in_ready_o;
  assign out_free    = ~out_valid_q | out_ready_i;
  assign out_valid_o = out_valid_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && command_i == CMD_RD_C) begin
          state_d = ST_RD_C;
        end else if (accept && command_i == CMD_COMPUTE && !stat_i.empty) begin
          state_d = ST_C_LD;
        end
      end
      ST_RD_C:  if (out_free) state_d = ST_IDLE;
      ST_C_LD:  state_d = ST_C_ACC;
      ST_C_ACC: state_d = ST_MUL;
      ST_AB_RD: state_d = ST_MUL;
      ST_MUL:   state_d = ST_MRND;
      ST_MRND:  state_d = ST_ADD;
      ST_ADD:   state_d = ST_ARND;
      ST_ARND:  state_d = stat_i.k_last ? ST_WB : ST_AB_RD;
      ST_WB:    state_d = (stat_i.i_last && stat_i.j_last) ? ST_IDLE : ST_C_LD;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl_o = '0;
    case (state_q)
      ST_IDLE: begin
        ctl_o.wr_a    = accept && command_i == CMD_WR_A;
        ctl_o.wr_b    = accept && command_i == CMD_WR_B;
        ctl_o.wr_c    = accept && command_i == CMD_WR_C;
        ctl_o.rd_host = accept && command_i == CMD_RD_C;
        ctl_o.ij_clr  = accept && command_i == CMD_COMPUTE;
        ctl_o.k_clr   = accept && command_i == CMD_COMPUTE;
      end
      ST_RD_C:  ctl_o.out_load = out_free;
      ST_C_LD:  ctl_o.c_rd = 1'b1;
      ST_C_ACC: begin
        ctl_o.acc_load = 1'b1;
        ctl_o.ab_rd    = 1'b1;
      end
      ST_AB_RD: ctl_o.ab_rd = 1'b1;
      ST_MUL:   ctl_o.mul_en = 1'b1;
      ST_MRND:  ctl_o.mrnd_en = 1'b1;
      ST_ADD:   ctl_o.add_en = 1'b1;
      ST_ARND: begin
        ctl_o.arnd_en = 1'b1;
        ctl_o.k_inc   = ~stat_i.k_last;
      end
      ST_WB: begin
        ctl_o.wb     = 1'b1;
        ctl_o.k_clr  = 1'b1;
        ctl_o.ij_inc = 1'b1;
      end
      default: ctl_o = '0;
    endcase
  end

  // output valid flag
  assign out_valid_d = ctl_o.out_load | (out_valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[src/fmma_datapath.sv]
// datapath: A, B and C stores, loop counters, binary32 multiply and add stages, result register
// depends on fmma_pkg

module fmma_datapath import fmma_pkg::*; #(
  parameter int unsigned MaxDim = MAX_DIM_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  fmma_in_t   in_data_i,
  input  logic [4:0] rows_m_i,
  input  logic [4:0] inner_k_i,
  input  logic [4:0] cols_n_i,
  input  fmma_ctl_t  ctl_i,
  output fmma_stat_t stat_o,
  output fmma_out_t  out_data_o
);

  localparam int unsigned Depth = MaxDim * MaxDim;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW    = $clog2(MaxDim + 1);

  logic [31:0] a_mem [Depth];
  logic [31:0] b_mem [Depth];
  logic [31:0] c_mem [Depth];

  logic [CW-1:0] m_use, k_use, n_use;
  logic [CW-1:0] i_q, j_q, k_q;
  logic          in_range;
  logic [AW-1:0] host_addr, ik_addr, kj_addr, ij_addr;
  logic [31:0]   a_rd_q, b_rd_q, c_rd_q;
  logic [3:0]    rd_row_q, rd_col_q;
  logic          rd_inside_q;
  logic          c_we;
  logic [AW-1:0] c_wa;
  logic [31:0]   c_wd;
  logic          c_re;
  logic [AW-1:0] c_ra;
  fmma_out_t     out_q;

  // multiply and add stage registers
  logic [47:0]        mp_q;
  logic               mp_sign_q, mp_nan_q, mp_inf_q, mp_zero_q;
  logic signed [11:0] mp_exp_q;
  logic [31:0]        prod_q;
  logic [50:0]        sm_mag_q;
  logic               sm_sign_q, sm_nan_q, sm_inf_q;
  logic [31:0]        sm_inf_val_q;
  logic signed [11:0] sm_exp_q;
  logic [31:0]        acc_q;

  // dimensions in use, clamped to the store size
  assign m_use = (32'(rows_m_i) > MaxDim) ? CW'(MaxDim) : CW'(rows_m_i);
  assign k_use = (32'(inner_k_i) > MaxDim) ? CW'(MaxDim) : CW'(inner_k_i);
  assign n_use = (32'(cols_n_i) > MaxDim) ? CW'(MaxDim) : CW'(cols_n_i);

  assign stat_o.empty  = (m_use == '0) || (k_use == '0) || (n_use == '0);
  assign stat_o.k_last = (k_q == k_use - CW'(1));
  assign stat_o.j_last = (j_q == n_use - CW'(1));
  assign stat_o.i_last = (i_q == m_use - CW'(1));

  // addresses
  assign in_range  = (32'(in_data_i.row) < MaxDim) && (32'(in_data_i.col) < MaxDim);
  assign host_addr = AW'(32'(in_data_i.row) * MaxDim + 32'(in_data_i.col));
  assign ik_addr   = AW'(32'(i_q) * MaxDim + 32'(k_q));
  assign kj_addr   = AW'(32'(k_q) * MaxDim + 32'(j_q));
  assign ij_addr   = AW'(32'(i_q) * MaxDim + 32'(j_q));

  // loop counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q <= '0;
      j_q <= '0;
      k_q <= '0;
    end else begin
      if (ctl_i.k_clr) begin
        k_q <= '0;
      end else if (ctl_i.k_inc) begin
        k_q <= k_q + CW'(1);
      end
      if (ctl_i.ij_clr) begin
        i_q <= '0;
        j_q <= '0;
      end else if (ctl_i.ij_inc) begin
        if (stat_o.j_last) begin
          j_q <= '0;
          i_q <= i_q + CW'(1);
        end else begin
          j_q <= j_q + CW'(1);
        end
      end
    end
  end

  // A and B stores
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_a && in_range) a_mem[host_addr] <= in_data_i.value;
    if (ctl_i.ab_rd) a_rd_q <= a_mem[ik_addr];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_b && in_range) b_mem[host_addr] <= in_data_i.value;
    if (ctl_i.ab_rd) b_rd_q <= b_mem[kj_addr];
  end

  // C store, shared by host access and compute write-back
  assign c_we = (ctl_i.wr_c && in_range) || ctl_i.wb;
  assign c_wa = ctl_i.wb ? ij_addr : host_addr;
  assign c_wd = ctl_i.wb ? acc_q : in_data_i.value;
  assign c_re = (ctl_i.rd_host && in_range) || ctl_i.c_rd;
  assign c_ra = ctl_i.c_rd ? ij_addr : host_addr;

  always_ff @(posedge clk_i) begin
    if (c_we) c_mem[c_wa] <= c_wd;
    if (c_re) c_rd_q <= c_mem[c_ra];
  end

  // read transaction bookkeeping and result register
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_host) begin
      rd_row_q    <= in_data_i.row;
      rd_col_q    <= in_data_i.col;
      rd_inside_q <= in_range;
    end
    if (ctl_i.out_load) begin
      out_q.row_res   <= rd_row_q;
      out_q.col_res   <= rd_col_q;
      out_q.value_res <= rd_inside_q ? c_rd_q : 32'h0;
    end
  end

  assign out_data_o = out_q;

  // multiply stage: operand decode and mantissa product
  always_ff @(posedge clk_i) begin
    logic [7:0]  ea, eb;
    logic [23:0] ma, mb;
    logic        a_inf, b_inf, a_nan, b_nan;
    if (ctl_i.mul_en) begin
      ea    = a_rd_q[30:23];
      eb    = b_rd_q[30:23];
      ma    = {|ea, a_rd_q[22:0]};
      mb    = {|eb, b_rd_q[22:0]};
      a_inf = (ea == 8'hFF) && (a_rd_q[22:0] == '0);
      b_inf = (eb == 8'hFF) && (b_rd_q[22:0] == '0);
      a_nan = (ea == 8'hFF) && (a_rd_q[22:0] != '0);
      b_nan = (eb == 8'hFF) && (b_rd_q[22:0] != '0);
      mp_q      <= 48'(ma) * 48'(mb);
      mp_sign_q <= a_rd_q[31] ^ b_rd_q[31];
      mp_exp_q  <= $signed({4'b0, (ea == 8'h00) ? 8'h01 : ea})
                 + $signed({4'b0, (eb == 8'h00) ? 8'h01 : eb}) - 12'sd127;
      mp_nan_q  <= a_nan || b_nan || (a_inf && mb == '0) || (b_inf && ma == '0);
      mp_inf_q  <= a_inf || b_inf;
      mp_zero_q <= (ma == '0) || (mb == '0);
    end
  end

  // product rounding stage
  always_ff @(posedge clk_i) begin
    if (ctl_i.mrnd_en) begin
      if (mp_nan_q) begin
        prod_q <= CANON_NAN;
      end else if (mp_inf_q) begin
        prod_q <= {mp_sign_q, 8'hFF, 23'b0};
      end else if (mp_zero_q) begin
        prod_q <= {mp_sign_q, 31'b0};
      end else begin
        prod_q <= norm_round(mp_sign_q, mp_exp_q, {mp_q, 3'b000});
      end
    end
  end

  // add stage: alignment and signed magnitude add
  always_ff @(posedge clk_i) begin
    logic        c_inf, p_inf, c_nan, p_nan, swap, sub;
    logic [31:0] big, sml;
    logic [7:0]  ebig, esml, d;
    logic [50:0] bfull, sfull, salign, smask;
    logic [50:0] mag;
    if (ctl_i.add_en) begin
      c_inf  = (acc_q[30:23] == 8'hFF) && (acc_q[22:0] == '0);
      p_inf  = (prod_q[30:23] == 8'hFF) && (prod_q[22:0] == '0);
      c_nan  = (acc_q[30:23] == 8'hFF) && (acc_q[22:0] != '0);
      p_nan  = (prod_q[30:23] == 8'hFF) && (prod_q[22:0] != '0);
      swap   = prod_q[30:0] > acc_q[30:0];
      big    = swap ? prod_q : acc_q;
      sml    = swap ? acc_q : prod_q;
      ebig   = (big[30:23] == 8'h00) ? 8'h01 : big[30:23];
      esml   = (sml[30:23] == 8'h00) ? 8'h01 : sml[30:23];
      d      = ebig - esml;
      bfull  = {1'b0, |big[30:23], big[22:0], 26'b0};
      sfull  = {1'b0, |sml[30:23], sml[22:0], 26'b0};
      smask  = '0;
      if (d > 8'd50) begin
        salign = {50'b0, |sfull};
      end else begin
        smask  = (51'(1) << d[5:0]) - 51'(1);
        salign = (sfull >> d[5:0]) | {50'b0, |(sfull & smask)};
      end
      sub = big[31] ^ sml[31];
      mag = sub ? (bfull - salign) : (bfull + salign);
      sm_mag_q     <= mag;
      sm_exp_q     <= $signed({4'b0, ebig});
      sm_sign_q    <= (mag == '0) ? (acc_q[31] & prod_q[31]) : big[31];
      sm_nan_q     <= c_nan || p_nan || (c_inf && p_inf && (acc_q[31] != prod_q[31]));
      sm_inf_q     <= c_inf || p_inf;
      sm_inf_val_q <= c_inf ? acc_q : prod_q;
    end
  end

  // sum rounding stage and accumulator
  always_ff @(posedge clk_i) begin
    if (ctl_i.acc_load) begin
      acc_q <= c_rd_q;
    end else if (ctl_i.arnd_en) begin
      if (sm_nan_q) begin
        acc_q <= CANON_NAN;
      end else if (sm_inf_q) begin
        acc_q <= sm_inf_val_q;
      end else begin
        acc_q <= norm_round(sm_sign_q, sm_exp_q, sm_mag_q);
      end
    end
  end

endmodule
